// ===== hdl/swq_pkg.sv =====
`timescale 1ns / 1ps

package swq_pkg;

	// Fixed field widths of the register file and result
	localparam int REG_IDX_W = 3;
	localparam int DATA_W    = 9;
	localparam int LEN_REG_W = 9;
	localparam int SYM_REG_W = 3;
	localparam int MIN_W     = 9;
	localparam int TOTAL_W   = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WINDOW_LEN = 3'd0,
		REG_SYMBOL_A   = 3'd1,
		REG_SYMBOL_B   = 3'd2,
		REG_MIN_A      = 3'd3,
		REG_MIN_B      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_REG_W-1:0] window_len;
		logic [SYM_REG_W-1:0] symbol_a;
		logic [SYM_REG_W-1:0] symbol_b;
		logic [MIN_W-1:0]     min_a;
		logic [MIN_W-1:0]     min_b;
	} cfg_t;

endpackage

// ===== hdl/swq_if.sv =====
`timescale 1ns / 1ps

interface swq_sym_if #(parameter int SYMBOL_BITS = 3);
	logic                   valid;
	logic                   ready;
	logic [SYMBOL_BITS-1:0] symbol;
	logic                   last;

	modport source(output valid, output symbol, output last, input ready);
	modport sink(input valid, input symbol, input last, output ready);
endinterface

interface swq_res_if;
	logic                          valid;
	logic                          ready;
	logic [swq_pkg::TOTAL_W-1:0]   windows_found;

	modport source(output valid, output windows_found, input ready);
	modport sink(input valid, input windows_found, output ready);
endinterface

// ===== hdl/swq_cfg.sv =====
`timescale 1ns / 1ps

module swq_cfg #(
	parameter int WINDOW_MAX = 256,
	parameter int LEN_W      = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [swq_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [swq_pkg::DATA_W-1:0]    wr_data,
	output swq_pkg::cfg_t                cfg,
	output logic [LEN_W-1:0]             len,
	output logic                         clear
);
	import swq_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_len <= LEN_REG_W'(1);
			cfg_q.symbol_a   <= SYM_REG_W'(0);
			cfg_q.symbol_b   <= SYM_REG_W'(1);
			cfg_q.min_a      <= '0;
			cfg_q.min_b      <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_WINDOW_LEN: cfg_q.window_len <= wr_data[LEN_REG_W-1:0];
				REG_SYMBOL_A:   cfg_q.symbol_a   <= wr_data[SYM_REG_W-1:0];
				REG_SYMBOL_B:   cfg_q.symbol_b   <= wr_data[SYM_REG_W-1:0];
				REG_MIN_A:      cfg_q.min_a      <= wr_data[MIN_W-1:0];
				REG_MIN_B:      cfg_q.min_b      <= wr_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Any write to a defined register restarts the sequence
	always_comb begin
		case (reg_idx_t'(wr_index))
			REG_WINDOW_LEN, REG_SYMBOL_A, REG_SYMBOL_B, REG_MIN_A, REG_MIN_B:
				clear = wr_en;
			default:
				clear = 1'b0;
		endcase
	end

	// Effective window: zero reads as one, large values clip to the ring depth
	always_comb begin
		if (cfg_q.window_len == '0) begin
			len = LEN_W'(1);
		end else if (int'(cfg_q.window_len) > WINDOW_MAX) begin
			len = LEN_W'(WINDOW_MAX);
		end else begin
			len = LEN_W'(cfg_q.window_len);
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/swq_ring.sv =====
`timescale 1ns / 1ps

module swq_ring #(
	parameter int WINDOW_MAX  = 256,
	parameter int SYMBOL_BITS = 3,
	parameter int LEN_W       = 9,
	parameter int SLOT_W      = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   accept_last,
	input  logic [LEN_W-1:0]       len,
	input  logic                   clear,
	input  logic                   step,
	input  logic [SYMBOL_BITS-1:0] sym_s1,
	output logic [SYMBOL_BITS-1:0] old_sym
);
	import swq_pkg::*;

	logic [SYMBOL_BITS-1:0] mem [0:WINDOW_MAX-1];

	logic [SLOT_W-1:0]      wptr_q;
	logic [SLOT_W-1:0]      slot_s1;
	logic [SYMBOL_BITS-1:0] rd_data_s1;
	logic                   byp_s1;
	logic [SYMBOL_BITS-1:0] byp_sym_s1;

	logic [LEN_W:0]         wptr_ext;
	logic [LEN_W:0]         len_ext;
	logic [LEN_W:0]         addr_sum;
	logic [SLOT_W-1:0]      rd_addr;

	// Slot of the symbol leaving the window when the incoming request is processed
	always_comb begin
		wptr_ext = (LEN_W+1)'(wptr_q);
		len_ext  = (LEN_W+1)'(len);
		if (wptr_ext >= len_ext) begin
			addr_sum = wptr_ext - len_ext;
		end else begin
			addr_sum = wptr_ext + (LEN_W+1)'(WINDOW_MAX) - len_ext;
		end
		rd_addr = addr_sum[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
		end else if (clear) begin
			wptr_q <= '0;
		end else if (accept) begin
			if (accept_last || wptr_q == SLOT_W'(WINDOW_MAX - 1)) begin
				wptr_q <= '0;
			end else begin
				wptr_q <= wptr_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mem[slot_s1] <= sym_s1;
		end
		if (accept) begin
			rd_data_s1 <= mem[rd_addr];
			slot_s1    <= wptr_q;
			// A one-deep window reads the slot being written this cycle
			byp_s1     <= step && (slot_s1 == rd_addr);
			byp_sym_s1 <= sym_s1;
		end
	end

	assign old_sym = byp_s1 ? byp_sym_s1 : rd_data_s1;

endmodule

// ===== hdl/swq_core.sv =====
`timescale 1ns / 1ps

module swq_core #(
	parameter int SYMBOL_BITS = 3,
	parameter int LEN_W       = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swq_pkg::cfg_t                cfg,
	input  logic [LEN_W-1:0]             len,
	input  logic                         clear,
	input  logic                         step,
	input  logic                         last,
	input  logic [SYMBOL_BITS-1:0]       sym,
	input  logic [SYMBOL_BITS-1:0]       old_sym,
	output logic [swq_pkg::TOTAL_W-1:0]  total
);
	import swq_pkg::*;

	localparam int EXT_W = (SYMBOL_BITS > SYM_REG_W) ? SYMBOL_BITS : SYM_REG_W;
	localparam int CMP_W = (LEN_W > MIN_W) ? LEN_W : MIN_W;
	localparam logic [EXT_W-1:0] SYM_MASK = EXT_W'((1 << SYMBOL_BITS) - 1);

	logic [LEN_W-1:0]   filled_q;
	logic [LEN_W-1:0]   count_a_q;
	logic [LEN_W-1:0]   count_b_q;
	logic [TOTAL_W-1:0] total_q;

	logic [EXT_W-1:0]   code_a;
	logic [EXT_W-1:0]   code_b;
	logic               new_a;
	logic               new_b;
	logic               old_a;
	logic               old_b;
	logic               full_before;
	logic               full_after;
	logic [LEN_W-1:0]   filled_d;
	logic [LEN_W-1:0]   count_a_dec;
	logic [LEN_W-1:0]   count_b_dec;
	logic [LEN_W-1:0]   count_a_d;
	logic [LEN_W-1:0]   count_b_d;
	logic               qualifies;

	// symbol_a takes precedence when both codes are equal
	always_comb begin
		code_a = EXT_W'(cfg.symbol_a) & SYM_MASK;
		code_b = EXT_W'(cfg.symbol_b) & SYM_MASK;
		new_a  = (EXT_W'(sym) == code_a);
		new_b  = !new_a && (EXT_W'(sym) == code_b);
		old_a  = (EXT_W'(old_sym) == code_a);
		old_b  = !old_a && (EXT_W'(old_sym) == code_b);
	end

	always_comb begin
		full_before = (filled_q >= len);
		filled_d    = full_before ? filled_q : filled_q + LEN_W'(1);
		full_after  = (filled_d >= len);

		count_a_dec = (full_before && old_a && count_a_q != '0) ?
			count_a_q - LEN_W'(1) : count_a_q;
		count_b_dec = (full_before && old_b && count_b_q != '0) ?
			count_b_q - LEN_W'(1) : count_b_q;
		count_a_d   = count_a_dec + LEN_W'(new_a);
		count_b_d   = count_b_dec + LEN_W'(new_b);

		qualifies = full_after
			&& (CMP_W'(count_a_d) >= CMP_W'(cfg.min_a))
			&& (CMP_W'(count_b_d) >= CMP_W'(cfg.min_b));

		if (qualifies && total_q != '1) begin
			total = total_q + TOTAL_W'(1);
		end else begin
			total = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q  <= '0;
			count_a_q <= '0;
			count_b_q <= '0;
			total_q   <= '0;
		end else if (clear || (step && last)) begin
			filled_q  <= '0;
			count_a_q <= '0;
			count_b_q <= '0;
			total_q   <= '0;
		end else if (step) begin
			filled_q  <= filled_d;
			count_a_q <= count_a_d;
			count_b_q <= count_b_d;
			total_q   <= total;
		end
	end

endmodule

// ===== hdl/sliding_window_two_symbol_quota_count.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                    Note
// symbols   in   symbol, last               one symbol per request
// results   out  windows_found[31:0]        one request per sequence, on last
// wr_*      in   wr_index, wr_data[8:0]     register write, no read-back
//
// One symbol per cycle sustained unless a last symbol waits on a held result.
// A request is registered into stage 1; the leaving symbol is read from the
// ring at acceptance; both counter updates, the window compares and the total
// increment finish in stage 1; a retiring last symbol registers the result.
// Reset clears the pointers, counters, total and valid flags; the ring holds
// garbage until written. A held result stalls only a last symbol in stage 1.

module sliding_window_two_symbol_quota_count #(
	parameter int WINDOW_MAX  = 256,
	parameter int SYMBOL_BITS = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [swq_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [swq_pkg::DATA_W-1:0]    wr_data,
	swq_sym_if.sink                       symbols,
	swq_res_if.source                     results
);
	import swq_pkg::*;

	localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
	localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	cfg_t                   cfg;
	logic [LEN_W-1:0]       len;
	logic                   clear;

	logic                   accept;
	logic                   step;
	logic                   valid_s1;
	logic [SYMBOL_BITS-1:0] sym_s1;
	logic                   last_s1;
	logic [SYMBOL_BITS-1:0] old_sym;
	logic [TOTAL_W-1:0]     total;

	logic                   out_valid_q;
	logic [TOTAL_W-1:0]     out_data_q;

	swq_cfg #(
		.WINDOW_MAX (WINDOW_MAX),
		.LEN_W      (LEN_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg),
		.len      (len),
		.clear    (clear)
	);

	// Stage 1 retires unless it holds a last symbol and the result slot is busy
	assign step   = valid_s1 && (!last_s1 || !out_valid_q || results.ready);
	assign symbols.ready = !valid_s1 || step;
	assign accept = symbols.valid && symbols.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_s1  <= symbols.symbol;
			last_s1 <= symbols.last;
		end
	end

	swq_ring #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SYMBOL_BITS (SYMBOL_BITS),
		.LEN_W       (LEN_W),
		.SLOT_W      (SLOT_W)
	) u_ring (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.accept_last (symbols.last),
		.len         (len),
		.clear       (clear),
		.step        (step),
		.sym_s1      (sym_s1),
		.old_sym     (old_sym)
	);

	swq_core #(
		.SYMBOL_BITS (SYMBOL_BITS),
		.LEN_W       (LEN_W)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.len     (len),
		.clear   (clear),
		.step    (step),
		.last    (last_s1),
		.sym     (sym_s1),
		.old_sym (old_sym),
		.total   (total)
	);

	// Result register: parts the output handshake from stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_data_q <= total;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.windows_found = out_data_q;

	// A retiring last symbol always lands in the result register
	a_last_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> out_valid_q && (out_data_q == $past(total)))
		else $error("last symbol retired without a result");

	// A pending result never gets overwritten by the next last symbol
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |-> !(step && last_s1))
		else $error("result overwritten while held");

	// Stage 1 holding a blocked last symbol takes no new request
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !results.ready |-> !symbols.ready)
		else $error("request taken while stage 1 is stalled");

endmodule
